FILE: sv/cascaded_attitude_pid_mixer_assert.svh
// ----------------------------------------------------------------------------
// cascaded attitude pid mixer assertion macros
// shared assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CASCADED_ATTITUDE_PID_MIXER_ASSERT_SVH
`define CASCADED_ATTITUDE_PID_MIXER_ASSERT_SVH

// same-cycle implication
`define CAPM_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capm assertion failed");

// next-cycle implication
`define CAPM_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capm assertion failed");

`endif

FILE: sv/capm_pkg.sv
// ----------------------------------------------------------------------------
// capm_pkg
// types, constants and saturation helpers for the attitude pid mixer
// ----------------------------------------------------------------------------
package capm_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NLOOPS    = 6;
    localparam int IN_W      = 240;
    localparam int OUT_W     = 152;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_W     = 42;
    localparam int ACC_W     = 60;

    localparam logic [CFG_IDX_W-1:0] REG_ROLL_ANGLE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_ANGLE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_ANGLE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_RATE   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATE  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DT_STEP     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE   = 8'd7;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_PITCH = 2'd1;
    localparam logic [1:0] MODE_ROLL  = 2'd2;
    localparam logic [1:0] MODE_YAW   = 2'd3;

    localparam logic [2:0] LOOP_LAST = 3'd5;

    localparam logic signed [25:0] HALF_TURN = 26'sd46080;
    localparam logic signed [25:0] FULL_TURN = 26'sd92160;
    localparam logic signed [26:0] MOTOR_MIN = 27'sd358400;
    localparam logic signed [26:0] MOTOR_MAX = 27'sd435200;
    localparam logic [15:0]        DT_RESET  = 16'd66;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_MEDT, S_INTEG, S_DLIM, S_WLIM, S_CLAMP, S_STINT,
        S_DDIF, S_WDIF, S_DERIV, S_MKP, S_AKP, S_MKI, S_AKI, S_MKDL, S_AKDL,
        S_MKDH, S_AKDH, S_OUT, S_MIX
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD_ERR, OP_MUL_EDT, OP_INTEG, OP_DIV_LIM, OP_CLAMP,
        OP_STORE_INT, OP_DIV_DIFF, OP_DERIV, OP_MUL_KP, OP_MUL_KI, OP_MUL_KDL,
        OP_MUL_KDH, OP_ACC, OP_ACC_HI, OP_OUT, OP_MIX
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] loop;
        logic       capture;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic ki_pos;
    } status_t;

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607)
            return 24'sh7fffff;
        else if (v < -27'sd8388608)
            return 24'sh800000;
        else
            return v[23:0];
    endfunction

endpackage

FILE: sv/capm_div.sv
// ----------------------------------------------------------------------------
// capm_div
// restoring divider, signed dividend by unsigned 16-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module capm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [capm_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]                       divisor,
    output logic                              busy,
    output logic                              done,
    output logic signed [capm_pkg::DIV_W-1:0] quotient
);
    import capm_pkg::*;

    localparam int MAG_W = DIV_W - 1;

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      trial;
    logic [DIV_W-1:0] abs_in;

    always_comb
    begin
        abs_in    = dividend[DIV_W-1] ? -dividend : dividend;
        trial     = {rem_reg, mag_reg[MAG_W-1]};
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = abs_in[MAG_W-1:0];
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'(MAG_W);
            neg_next  = dividend[DIV_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
                mag_next = {mag_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

FILE: sv/capm_datapath.sv
// ----------------------------------------------------------------------------
// capm_datapath
// configuration registers, loop state, shared multiplier and divider, mixer
// ----------------------------------------------------------------------------
module capm_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  capm_pkg::cmd_t                     cmd,
    output capm_pkg::status_t                  status,
    input  logic [capm_pkg::IN_W-1:0]          in_tdata,
    input  logic                               cfg_we,
    input  logic [capm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                        cfg_data,
    output logic [capm_pkg::OUT_W-1:0]         out_tdata
);
    import capm_pkg::*;

    logic [63:0]               gains_reg [NLOOPS];
    logic [15:0]               dt_reg;
    logic [1:0]                mode_reg;
    logic signed [31:0]        integ_mem [NLOOPS];
    logic signed [23:0]        last_mem [NLOOPS];
    logic [IN_W-1:0]           in_reg;
    logic signed [23:0]        pid_out_reg [NLOOPS];
    logic signed [23:0]        e_reg, e_next;
    logic signed [31:0]        integ_reg, integ_next;
    logic signed [DIV_W-1:0]   deriv_reg;
    logic signed [49:0]        prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [OUT_W-1:0]          out_reg;

    logic [63:0]               gains;
    logic signed [15:0]        kp, ki, kd;
    logic [15:0]               lim, dt_eff;
    logic signed [16:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic                      div_start, div_busy, div_done;
    logic signed [DIV_W-1:0]   div_dividend, quotient;
    logic [15:0]               div_divisor;
    logic signed [24:0]        diff;
    logic signed [25:0]        yaw_raw;
    logic signed [34:0]        integ_sum;
    logic signed [DIV_W-1:0]   integ_x;
    logic signed [ACC_W-FRAC_BITS-1:0] pid_sh;
    logic signed [ACC_W-FRAC_BITS-1:0] lim_s;
    logic signed [ACC_W-FRAC_BITS-1:0] pid_c;
    logic signed [23:0]        cr, cp, cy;
    logic signed [26:0]        base, m0, m1, m2, m3;

    function automatic logic signed [23:0] fld(input logic [IN_W-1:0] d, input int k);
        return d[k*24 +: 24];
    endfunction

    function automatic logic [18:0] mclamp(input logic signed [26:0] v);
        if (v < MOTOR_MIN)
            return MOTOR_MIN[18:0];
        else if (v > MOTOR_MAX)
            return MOTOR_MAX[18:0];
        else
            return v[18:0];
    endfunction

    assign gains  = gains_reg[cmd.loop];
    assign kp     = gains[15:0];
    assign ki     = gains[31:16];
    assign kd     = gains[47:32];
    assign lim    = gains[63:48];
    assign dt_eff = (dt_reg == 16'd0) ? 16'd1 : dt_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = {kp[15], kp};
        mul_b = 33'(e_reg);
        case (cmd.op)
            OP_MUL_EDT:
            begin
                mul_a = {1'b0, dt_eff};
                mul_b = 33'(e_reg);
            end
            OP_MUL_KI:
            begin
                mul_a = {ki[15], ki};
                mul_b = 33'(integ_reg);
            end
            OP_MUL_KDL:
            begin
                mul_a = {kd[15], kd};
                mul_b = $signed({12'd0, deriv_reg[20:0]});
            end
            OP_MUL_KDH:
            begin
                mul_a = {kd[15], kd};
                mul_b = 33'($signed(deriv_reg[DIV_W-1:21]));
            end
            default:
            begin
                mul_a = {kp[15], kp};
                mul_b = 33'(e_reg);
            end
        endcase
    end

    assign diff      = 25'(e_reg) - 25'(last_mem[cmd.loop]);
    assign div_start = (cmd.op == OP_DIV_LIM) || (cmd.op == OP_DIV_DIFF);
    assign div_dividend = (cmd.op == OP_DIV_LIM) ? $signed({10'd0, lim, 16'd0})
                                                 : $signed({diff, 17'd0}) >>> 1;
    assign div_divisor  = (cmd.op == OP_DIV_LIM) ? ki : dt_eff;

    capm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.ki_pos   = !ki[15] && (ki != 16'd0);

    // error, integral, accumulator updates
    always_comb
    begin
        yaw_raw    = 26'(fld(in_reg, 2)) - 26'(fld(in_reg, 5));
        integ_sum  = 35'(integ_mem[cmd.loop]) + 35'(prod_reg >>> 16);
        integ_x    = DIV_W'(integ_reg);
        pid_sh     = acc_reg[ACC_W-1:FRAC_BITS];
        lim_s      = $signed({28'd0, lim, 8'd0});
        e_next     = e_reg;
        integ_next = integ_reg;
        acc_next   = acc_reg;
        pid_c      = pid_sh;
        if (yaw_raw > HALF_TURN)
            yaw_raw = yaw_raw - FULL_TURN;
        else if (yaw_raw < -HALF_TURN)
            yaw_raw = yaw_raw + FULL_TURN;
        if (pid_sh > lim_s)
            pid_c = lim_s;
        else if (pid_sh < -lim_s)
            pid_c = -lim_s;
        case (cmd.op)
            OP_LOAD_ERR:
            begin
                case (cmd.loop)
                    3'd0: e_next = sat24(27'(fld(in_reg, 0)) - 27'(fld(in_reg, 3)));
                    3'd1: e_next = sat24(27'(fld(in_reg, 1)) - 27'(fld(in_reg, 4)));
                    3'd2: e_next = sat24(27'(yaw_raw));
                    3'd3: e_next = sat24(27'(pid_out_reg[0]) - 27'(fld(in_reg, 6)));
                    3'd4: e_next = sat24(27'(pid_out_reg[1]) - 27'(fld(in_reg, 7)));
                    default: e_next = sat24(27'(pid_out_reg[2]) - 27'(fld(in_reg, 8)));
                endcase
            end
            OP_INTEG:
            begin
                if (integ_sum > 35'sd2147483647)
                    integ_next = 32'sh7fffffff;
                else if (integ_sum < -35'sd2147483648)
                    integ_next = 32'sh80000000;
                else
                    integ_next = integ_sum[31:0];
            end
            OP_CLAMP:
            begin
                if (integ_x > quotient)
                    integ_next = quotient[31:0];
                else if (integ_x < -quotient)
                    integ_next = 32'(-quotient);
            end
            OP_DERIV:   acc_next = '0;
            OP_ACC:     acc_next = acc_reg + ACC_W'(prod_reg);
            OP_ACC_HI:  acc_next = acc_reg + (ACC_W'(prod_reg) <<< 21);
            default:    acc_next = acc_reg;
        endcase
    end

    // mixer
    always_comb
    begin
        cr = pid_out_reg[3];
        cp = pid_out_reg[4];
        cy = pid_out_reg[5];
        case (mode_reg)
            MODE_PITCH:
            begin
                cr = '0;
                cy = '0;
            end
            MODE_ROLL:
            begin
                cp = '0;
                cy = '0;
            end
            MODE_YAW:
            begin
                cr = '0;
                cp = '0;
            end
            default: ;
        endcase
        base = $signed({7'd0, in_reg[235:216]});
        m0 = base + 27'(cp) + 27'(cr) + 27'(cy);
        m1 = base + 27'(cp) - 27'(cr) - 27'(cy);
        m2 = base - 27'(cp) + 27'(cr) - 27'(cy);
        m3 = base - 27'(cp) - 27'(cr) + 27'(cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NLOOPS; i++)
            begin
                gains_reg[i] <= '0;
                integ_mem[i] <= '0;
                last_mem[i]  <= '0;
            end
            dt_reg   <= DT_RESET;
            mode_reg <= MODE_PITCH;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROLL_ANGLE:  gains_reg[0] <= cfg_data;
                    REG_PITCH_ANGLE: gains_reg[1] <= cfg_data;
                    REG_YAW_ANGLE:   gains_reg[2] <= cfg_data;
                    REG_ROLL_RATE:   gains_reg[3] <= cfg_data;
                    REG_PITCH_RATE:  gains_reg[4] <= cfg_data;
                    REG_YAW_RATE:    gains_reg[5] <= cfg_data;
                    REG_DT_STEP:     dt_reg <= cfg_data[15:0];
                    REG_AXIS_MODE:   mode_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_STORE_INT)
                integ_mem[cmd.loop] <= integ_reg;
            if (cmd.op == OP_DERIV)
                last_mem[cmd.loop] <= e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_tdata;
        e_reg     <= e_next;
        integ_reg <= integ_next;
        acc_reg   <= acc_next;
        prod_reg  <= mul_a * mul_b;
        if (cmd.op == OP_DERIV)
            deriv_reg <= quotient;
        if (cmd.op == OP_OUT)
            pid_out_reg[cmd.loop] <= sat24(27'(pid_c));
        if (cmd.op == OP_MIX)
            out_reg <= {4'd0, mclamp(m3), mclamp(m2), mclamp(m1), mclamp(m0),
                        pid_out_reg[2], pid_out_reg[1], pid_out_reg[0]};
    end

    assign out_tdata = out_reg;

endmodule

FILE: sv/capm_ctrl.sv
// ----------------------------------------------------------------------------
// capm_ctrl
// sequencer stepping the six pid loops through the shared datapath
// ----------------------------------------------------------------------------
module capm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    output logic              out_tvalid,
    input  logic              out_tready,
    input  capm_pkg::status_t status,
    output capm_pkg::cmd_t    cmd
);
    import capm_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] loop_reg, loop_next;
    logic       oval_reg, oval_next;
    op_t        op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            loop_reg  <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            loop_reg  <= loop_next;
            oval_reg  <= oval_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        loop_next  = loop_reg;
        oval_next  = oval_reg && !out_tready;
        op         = OP_NONE;
        in_tready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                loop_next = '0;
                if (in_tvalid)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                op = OP_LOAD_ERR;
                state_next = S_MEDT;
            end
            S_MEDT:
            begin
                op = OP_MUL_EDT;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                op = OP_INTEG;
                state_next = status.ki_pos ? S_DLIM : S_STINT;
            end
            S_DLIM:
            begin
                op = OP_DIV_LIM;
                state_next = S_WLIM;
            end
            S_WLIM:
            begin
                if (status.div_done)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                op = OP_CLAMP;
                state_next = S_STINT;
            end
            S_STINT:
            begin
                op = OP_STORE_INT;
                state_next = S_DDIF;
            end
            S_DDIF:
            begin
                op = OP_DIV_DIFF;
                state_next = S_WDIF;
            end
            S_WDIF:
            begin
                if (status.div_done)
                    state_next = S_DERIV;
            end
            S_DERIV:
            begin
                op = OP_DERIV;
                state_next = S_MKP;
            end
            S_MKP:
            begin
                op = OP_MUL_KP;
                state_next = S_AKP;
            end
            S_AKP:
            begin
                op = OP_ACC;
                state_next = S_MKI;
            end
            S_MKI:
            begin
                op = OP_MUL_KI;
                state_next = S_AKI;
            end
            S_AKI:
            begin
                op = OP_ACC;
                state_next = S_MKDL;
            end
            S_MKDL:
            begin
                op = OP_MUL_KDL;
                state_next = S_AKDL;
            end
            S_AKDL:
            begin
                op = OP_ACC;
                state_next = S_MKDH;
            end
            S_MKDH:
            begin
                op = OP_MUL_KDH;
                state_next = S_AKDH;
            end
            S_AKDH:
            begin
                op = OP_ACC_HI;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                op = OP_OUT;
                if (loop_reg == LOOP_LAST)
                    state_next = S_MIX;
                else
                begin
                    loop_next  = loop_reg + 3'd1;
                    state_next = S_ERR;
                end
            end
            S_MIX:
            begin
                if (!oval_reg || out_tready)
                begin
                    op = OP_MIX;
                    oval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd.op      = op;
    assign cmd.loop    = loop_reg;
    assign cmd.capture = in_tvalid && in_tready;
    assign out_tvalid  = oval_reg;

endmodule

FILE: sv/cascaded_attitude_pid_mixer.sv
// the six pid loops run one after another through the shared one-bit-a-cycle divider,
// which divides once per pid loop, twice when ki > 0; a new item is accepted only
// after the previous one has passed all six loops and the mixing step
// the result register holds while the next item is accepted; an unaccepted result
// holds the next item at the mixing step
// reset: asynchronous active low; gains, loop state clear, dt 66, axis mode 1
// ----------------------------------------------------------------------------
// cascaded_attitude_pid_mixer
// cascaded angle and rate pid controller with x-frame motor mixer
// ----------------------------------------------------------------------------
`include "cascaded_attitude_pid_mixer_assert.svh"

module cascaded_attitude_pid_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // target_roll, target_pitch, target_yaw, measured_roll, measured_pitch,
    // measured_yaw, gyro_x, gyro_y, gyro_z, base_throttle
    input  logic [capm_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // roll_rate_target, pitch_rate_target, yaw_rate_target, motor_front_right,
    // motor_front_left, motor_back_right, motor_back_left
    output logic [capm_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [capm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                        cfg_data
);
    import capm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    capm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    capm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_tdata  (s_axis_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_tdata (m_axis_tdata)
    );

    `CAPM_ASSERT_IMP(a_div_idle_start, (cmd.op == OP_DIV_LIM) || (cmd.op == OP_DIV_DIFF), !status.div_busy)
    `CAPM_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CAPM_ASSERT_IMP(a_result_from_mix, $rose(m_axis_tvalid), $past(cmd.op == OP_MIX))

endmodule

FILE: tb/tb_cascaded_attitude_pid_mixer.sv
// ----------------------------------------------------------------------------
// tb_cascaded_attitude_pid_mixer
// self-checking bench for the cascaded attitude pid controller and x mixer.
// a directed table covers throttle and motor clamp limits, saturating angle
// errors, yaw wrap in both directions and extreme gyro rates; random control
// ticks follow under a series of gain, period and axis mode settings. each
// result is checked field by field: the first table pass against its typed
// values, the rest against a bit-exact predictor holding its own six loop states.
// ----------------------------------------------------------------------------
module tb_cascaded_attitude_pid_mixer;
    timeunit 1ns;
    timeprecision 1ps;

    import capm_pkg::*;

    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 140;

    typedef struct {
        longint tr, tp, ty, mr, mp, my, gx, gy, gz, thr;
        bit     typed;
        longint motor;
    } tick_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    // own copy of configuration and loop state
    logic [63:0]          gains_q [6];
    logic [15:0]          period_q;
    logic [1:0]           mode_q;
    longint               integ_q [6];
    longint               prev_err_q [6];

    logic [OUT_W-1:0]     pending_results [$];
    int                   mismatches;
    int                   results_seen;
    int                   items_sent;
    bit                   calm;

    cascaded_attitude_pid_mixer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint pid_tick(int idx, logic [63:0] g, longint e, longint dt);
        longint kp  = longint'($signed(g[15:0]));
        longint ki  = longint'($signed(g[31:16]));
        longint kd  = longint'($signed(g[47:32]));
        longint lim = longint'(g[63:48]);
        longint integ, deriv, sum, res;
        integ = clamp64(integ_q[idx] + ((e * dt) >>> 16), -64'sd2147483648, 64'sd2147483647);
        if (ki > 0)
            integ = clamp64(integ, -((lim << 16) / ki), (lim << 16) / ki);
        integ_q[idx] = integ;
        deriv = ((e - prev_err_q[idx]) * 65536) / dt;
        prev_err_q[idx] = e;
        sum = kp * e + ki * integ + kd * deriv;
        res = clamp64(sum >>> FRAC_BITS, -(lim << FRAC_BITS), lim << FRAC_BITS);
        return clamp64(res, -8388608, 8388607);
    endfunction

    function automatic longint s24(logic [IN_W-1:0] d, int n);
        return longint'($signed(d[n*24 +: 24]));
    endfunction

    function automatic logic [OUT_W-1:0] control_tick(logic [IN_W-1:0] d);
        longint dt = (period_q == 16'd0) ? 1 : longint'(period_q);
        longint er, ep, ey, rr, rp, ry, cr, cp, cy, base, m;
        logic [OUT_W-1:0] r;
        er = clamp64(s24(d, 0) - s24(d, 3), -8388608, 8388607);
        ep = clamp64(s24(d, 1) - s24(d, 4), -8388608, 8388607);
        ey = s24(d, 2) - s24(d, 5);
        if (ey > longint'(HALF_TURN))
            ey -= longint'(FULL_TURN);
        else if (ey < -longint'(HALF_TURN))
            ey += longint'(FULL_TURN);
        ey = clamp64(ey, -8388608, 8388607);
        rr = pid_tick(0, gains_q[0], er, dt);
        rp = pid_tick(1, gains_q[1], ep, dt);
        ry = pid_tick(2, gains_q[2], ey, dt);
        cr = pid_tick(3, gains_q[3], clamp64(rr - s24(d, 6), -8388608, 8388607), dt);
        cp = pid_tick(4, gains_q[4], clamp64(rp - s24(d, 7), -8388608, 8388607), dt);
        cy = pid_tick(5, gains_q[5], clamp64(ry - s24(d, 8), -8388608, 8388607), dt);
        case (mode_q)
            MODE_PITCH: begin cr = 0; cy = 0; end
            MODE_ROLL:  begin cp = 0; cy = 0; end
            MODE_YAW:   begin cr = 0; cp = 0; end
            default:    ;
        endcase
        base = longint'(d[216 +: 20]);
        r = '0;
        r[0 +: 24]  = rr[23:0];
        r[24 +: 24] = rp[23:0];
        r[48 +: 24] = ry[23:0];
        m = clamp64(base + cp + cr + cy, MOTOR_MIN, MOTOR_MAX);
        r[72 +: 19] = m[18:0];
        m = clamp64(base + cp - cr - cy, MOTOR_MIN, MOTOR_MAX);
        r[91 +: 19] = m[18:0];
        m = clamp64(base - cp + cr - cy, MOTOR_MIN, MOTOR_MAX);
        r[110 +: 19] = m[18:0];
        m = clamp64(base - cp - cr + cy, MOTOR_MIN, MOTOR_MAX);
        r[129 +: 19] = m[18:0];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_tick(tick_row_t t);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: 24]   = t.tr[23:0];
        d[24 +: 24]  = t.tp[23:0];
        d[48 +: 24]  = t.ty[23:0];
        d[72 +: 24]  = t.mr[23:0];
        d[96 +: 24]  = t.mp[23:0];
        d[120 +: 24] = t.my[23:0];
        d[144 +: 24] = t.gx[23:0];
        d[168 +: 24] = t.gy[23:0];
        d[192 +: 24] = t.gz[23:0];
        d[216 +: 20] = t.thr[19:0];
        return d;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DT_STEP:   period_q = val[15:0];
            REG_AXIS_MODE: mode_q = val[1:0];
            default:       if (idx < 6) gains_q[idx] = val;
        endcase
    endtask

    // the task leaves tvalid high after the transaction
    task automatic send_tick(logic [IN_W-1:0] d, bit typed, logic [OUT_W-1:0] typed_res);
        int gap;
        logic [OUT_W-1:0] r;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        r = control_tick(d);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_gains(bit wild);
        logic [15:0] kp, ki, kd, lim;
        if (wild)
            return {$urandom, $urandom};
        kp  = 16'($urandom_range(0, 1024));
        ki  = 16'(int'($urandom_range(0, 320)) - 64);
        kd  = 16'($urandom_range(0, 64));
        lim = 16'($urandom_range(50, 600));
        return {lim, kd, ki, kp};
    endfunction

    function automatic longint pick_s24(int span);
        if ($urandom_range(0, 6) == 0)
            return longint'($signed(24'($urandom)));
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [IN_W-1:0] random_tick();
        tick_row_t t;
        if ($urandom_range(0, 9) == 0)
            return IN_W'({$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom});
        t.tr  = pick_s24(15360);
        t.tp  = pick_s24(15360);
        t.ty  = pick_s24(51200);
        t.mr  = pick_s24(15360);
        t.mp  = pick_s24(15360);
        t.my  = pick_s24(51200);
        t.gx  = pick_s24(128000);
        t.gy  = pick_s24(128000);
        t.gz  = pick_s24(128000);
        t.thr = $urandom_range(0, 4) == 0 ? longint'($urandom_range(0, 1048575))
                                          : longint'($urandom_range(350000, 445000));
        return pack_tick(t);
    endfunction

    // result side: random stalls, field by field compare
    initial
    begin
        logic [OUT_W-1:0] want;
        int stall, off, w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int f = 0; f < 7; f++)
                begin
                    off = f < 3 ? f * 24 : 72 + (f - 3) * 19;
                    w   = f < 3 ? 24 : 19;
                    if (((want ^ m_axis_tdata) >> off) & ((152'd1 << w) - 1))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d field %0d: expected %h, got %h",
                                     results_seen, f,
                                     (want >> off) & ((152'd1 << w) - 1),
                                     (m_axis_tdata >> off) & ((152'd1 << w) - 1));
                    end
                end
            end
        end
    end

    initial
    begin
        tick_row_t rows [12];
        logic [OUT_W-1:0] typed_res;
        logic [63:0] g;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        calm          = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            gains_q[i]    = '0;
            integ_q[i]    = 0;
            prev_err_q[i] = 0;
        end
        period_q = DT_RESET;
        mode_q   = MODE_PITCH;

        //            tr        tp        ty        mr        mp        my
        //            gx        gy        gz        thr      typed motor
        rows[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 358400};
        rows[1]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1048575, 1, 435200};
        rows[2]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 396800, 1, 396800};
        rows[3]  = '{8388607, 0, 0, -8388608, 0, 0, 0, 0, 0, 358400, 1, 358400};
        rows[4]  = '{0, -8388608, 0, 0, 8388607, 0, 0, 0, 0, 435200, 1, 435200};
        rows[5]  = '{0, 0, 43520, 0, 0, -43520, 0, 0, 0, 435201, 1, 435200};
        rows[6]  = '{0, 0, -43520, 0, 0, 43520, 0, 0, 0, 358399, 1, 358400};
        rows[7]  = '{0, 0, 8388607, 0, 0, -8388608, 0, 0, 0, 400000, 1, 400000};
        rows[8]  = '{0, 0, -8388608, 0, 0, 8388607, 0, 0, 0, 400000, 1, 400000};
        rows[9]  = '{0, 0, 46080, 0, 0, 0, 8388607, 8388607, 8388607, 400000, 1, 400000};
        rows[10] = '{0, 0, -46081, 0, 0, 0, -8388608, -8388608, -8388608, 400000, 1, 400000};
        rows[11] = '{2560, -2560, 1280, 0, 0, 0, 5000, -5000, 2000, 396800, 1, 396800};

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero gains, so only the throttle reaches the motors
        foreach (rows[i])
        begin
            typed_res = '0;
            for (int k = 0; k < 4; k++)
                typed_res[72 + k * 19 +: 19] = rows[i].motor[18:0];
            send_tick(pack_tick(rows[i]), rows[i].typed, typed_res);
        end
        wait_idle();

        // same table with live gains on all axes
        for (int i = 0; i < 6; i++)
            write_reg(CFG_IDX_W'(i), {16'd400, 16'd8, 16'd32, 16'd256});
        write_reg(REG_DT_STEP, 64'd66);
        write_reg(REG_AXIS_MODE, {62'd0, MODE_FULL});
        foreach (rows[i])
            send_tick(pack_tick(rows[i]), 1'b0, '0);
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            for (int i = 0; i < 6; i++)
            begin
                g = pick_gains(ph == 3 || ph == 7);
                if (ph == 1)
                    g[31:16] = 16'h8000;
                if (ph == 2)
                    g = {16'hffff, 16'h7fff, 16'h7fff, 16'h7fff};
                if (ph == 5)
                    g[63:48] = 16'd0;
                write_reg(CFG_IDX_W'(i), g);
            end
            case (ph)
                1:       write_reg(REG_DT_STEP, 64'hdead_0000_0000_0000);
                2:       write_reg(REG_DT_STEP, 64'h0000_0000_0000_ffff);
                4:       write_reg(REG_DT_STEP, 64'd1);
                default: write_reg(REG_DT_STEP, {$urandom, 16'd0, 16'($urandom_range(1, 4000))});
            endcase
            write_reg(REG_AXIS_MODE, {$urandom, 30'($urandom), 2'(ph)});
            write_reg(CFG_IDX_W'(8 + $urandom_range(0, 247)), {$urandom, $urandom});
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (n % 40 == 0)
                    calm = $urandom_range(0, 3) == 0;
                send_tick(random_tick(), 1'b0, '0);
            end
            calm = 1'b0;
            wait_idle();
        end

        repeat (700) @(posedge clk);
        $display("%0d control ticks sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("covered %0d gain settings, all axis modes, yaw wrap and saturation",
                 N_PHASES + 2);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: cascaded_attitude_pid_mixer.f
+incdir+sv
sv/capm_pkg.sv
sv/capm_div.sv
sv/capm_datapath.sv
sv/capm_ctrl.sv
sv/cascaded_attitude_pid_mixer.sv
tb/tb_cascaded_attitude_pid_mixer.sv
